/* hdl/dtq_pkg.sv */
// Package for the delta-list timer queue: sizes, command and status codes,
// sequencer states and the structs between the list store and the sequencer.
// No dependencies.
package dtq_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
	localparam int DELAY_W    = 32;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOT_COUNT);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_EXPIRED  = 2'd1;
	localparam logic [1:0] STATUS_REJECTED = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESP,
		ST_INS_WALK,
		ST_INS_LINK,
		ST_INS_FIX_PREV,
		ST_INS_FIX_NEXT,
		ST_RM_READ,
		ST_RM_FIX_NEXT,
		ST_RM_FIX_PREV,
		ST_TICK_SUB,
		ST_TICK_CHECK,
		ST_TICK_NEXT,
		ST_TICK_ADD
	} dtq_state_t;

	typedef struct packed {
		logic                      en_delay;
		logic                      en_next;
		logic                      en_prev;
		logic [SLOT_W-1:0]         addr;
		logic signed [DELAY_W-1:0] delay;
		logic [LINK_W-1:0]         next;
		logic [LINK_W-1:0]         prev;
	} dtq_wr_t;

	typedef struct packed {
		logic signed [DELAY_W-1:0] delay;
		logic [LINK_W-1:0]         next;
		logic [LINK_W-1:0]         prev;
	} dtq_rd_t;

endpackage

/* hdl/dtq_alu.sv */
// Shared add/subtract unit of the timer queue, with the sign of the full result.
// Depends on dtq_pkg.
module dtq_alu (
	input  logic signed [dtq_pkg::DELAY_W-1:0] a,
	input  logic signed [dtq_pkg::DELAY_W-1:0] b,
	input  logic                               sub,
	output logic signed [dtq_pkg::DELAY_W-1:0] sum,
	output logic                               neg
);

	logic signed [dtq_pkg::DELAY_W:0] wide;

	always_comb begin
		if (sub) begin
			wide = {a[dtq_pkg::DELAY_W-1], a} - {b[dtq_pkg::DELAY_W-1], b};
		end else begin
			wide = {a[dtq_pkg::DELAY_W-1], a} + {b[dtq_pkg::DELAY_W-1], b};
		end
	end

	assign sum = wide[dtq_pkg::DELAY_W-1:0];
	assign neg = wide[dtq_pkg::DELAY_W];

endmodule

/* hdl/dtq_store.sv */
// Per-slot list store: relative delay, next link and previous link.
// One read address and one write address per cycle. Depends on dtq_pkg.
module dtq_store (
	input  logic                        clk,
	input  logic [dtq_pkg::SLOT_W-1:0]  rd_addr,
	output dtq_pkg::dtq_rd_t            rd,
	input  dtq_pkg::dtq_wr_t            wr
);

	logic signed [dtq_pkg::DELAY_W-1:0] delay_q [dtq_pkg::SLOT_COUNT];
	logic [dtq_pkg::LINK_W-1:0]         next_q  [dtq_pkg::SLOT_COUNT];
	logic [dtq_pkg::LINK_W-1:0]         prev_q  [dtq_pkg::SLOT_COUNT];

	// Entries hold no reset value; they are only read for slots in the list.
	always_ff @(posedge clk) begin
		if (wr.en_delay) begin
			delay_q[wr.addr] <= wr.delay;
		end
		if (wr.en_next) begin
			next_q[wr.addr] <= wr.next;
		end
		if (wr.en_prev) begin
			prev_q[wr.addr] <= wr.prev;
		end
	end

	assign rd.delay = delay_q[rd_addr];
	assign rd.next  = next_q[rd_addr];
	assign rd.prev  = prev_q[rd_addr];

endmodule

/* hdl/delta_delay_timer_queue_core.sv */
// Delta-list timer queue, top level: sequencer, membership flags, output register.
// Insert into the list walks the entries ahead, links the slot and fixes its neighbours;
// remove from the list unlinks the slot and fixes its neighbours; any other insert or remove,
// a rejected request and a tick on an empty list go straight to the response. Each entry walked
// or expired takes its turn on the one shared adder, and a stalled result holds the sequencer.
// One request at a time; reset clears the membership flags, the list head and output valid.
module delta_delay_timer_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  slot_id,
	input  logic [30:0] delay_ticks,
	input  logic        wait_forever,
	input  logic [15:0] tick_delta,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  expired_slot,
	output logic        last
);

	localparam int SW = dtq_pkg::SLOT_W;
	localparam int LW = dtq_pkg::LINK_W;
	localparam int DW = dtq_pkg::DELAY_W;

	dtq_pkg::dtq_state_t state_q, state_d;

	logic [dtq_pkg::SLOT_COUNT-1:0] in_list_q, in_list_d;
	logic [dtq_pkg::SLOT_COUNT-1:0] in_wait_q, in_wait_d;
	logic [LW-1:0]                  head_q, head_d;
	logic                           have_pend_q, have_pend_d;

	logic [LW-1:0]         slot_q, slot_d;
	logic [LW-1:0]         cur_q, cur_d;
	logic [LW-1:0]         prv_q, prv_d;
	logic [LW-1:0]         pend_q, pend_d;
	logic signed [DW-1:0]  dly_q, dly_d;
	logic [15:0]           elapsed_q, elapsed_d;
	logic [1:0]            resp_q, resp_d;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [3:0]  expired_q;
	logic        last_q;

	logic                 emit_req;
	logic [1:0]           em_status;
	logic [LW-1:0]        em_slot;
	logic                 em_last;
	logic                 out_free;

	logic signed [DW-1:0] alu_a, alu_b, alu_sum;
	logic                 alu_sub, alu_neg;

	dtq_pkg::dtq_rd_t rd;
	dtq_pkg::dtq_wr_t wr;

	logic          slot_ok;
	logic [SW-1:0] sidx;
	logic          member, waiting;
	logic          expire;

	dtq_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum),
		.neg (alu_neg)
	);

	dtq_store u_store (
		.clk     (clk),
		.rd_addr (cur_q[SW-1:0]),
		.rd      (rd),
		.wr      (wr)
	);

	assign in_stall = (state_q != dtq_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign slot_ok = (32'(slot_id) < dtq_pkg::SLOT_COUNT);
	assign sidx    = SW'(slot_id);
	assign member  = slot_ok && in_list_q[sidx];
	assign waiting = slot_ok && in_wait_q[sidx];
	assign expire  = dly_q[DW-1] || (dly_q == '0);

	always_comb begin
		state_d     = state_q;
		in_list_d   = in_list_q;
		in_wait_d   = in_wait_q;
		head_d      = head_q;
		have_pend_d = have_pend_q;
		slot_d      = slot_q;
		cur_d       = cur_q;
		prv_d       = prv_q;
		pend_d      = pend_q;
		dly_d       = dly_q;
		elapsed_d   = elapsed_q;
		resp_d      = resp_q;
		alu_a       = rd.delay;
		alu_b       = dly_q;
		alu_sub     = 1'b0;
		wr          = '0;
		emit_req    = 1'b0;
		em_status   = dtq_pkg::STATUS_DONE;
		em_slot     = '0;
		em_last     = 1'b1;

		case (state_q)
			dtq_pkg::ST_IDLE: begin
				if (in_valid) begin
					slot_d    = LW'(slot_id);
					cur_d     = LW'(slot_id);
					elapsed_d = tick_delta;
					resp_d    = dtq_pkg::STATUS_DONE;
					state_d   = dtq_pkg::ST_RESP;
					case (command)
						dtq_pkg::CMD_INSERT: begin
							if (!slot_ok || member || waiting) begin
								resp_d = dtq_pkg::STATUS_REJECTED;
							end else if (wait_forever) begin
								in_wait_d[sidx] = 1'b1;
							end else begin
								dly_d   = DW'(delay_ticks);
								cur_d   = head_q;
								prv_d   = dtq_pkg::NIL_LINK;
								state_d = dtq_pkg::ST_INS_WALK;
							end
						end
						dtq_pkg::CMD_REMOVE: begin
							if (member) begin
								state_d = dtq_pkg::ST_RM_READ;
							end else if (waiting) begin
								in_wait_d[sidx] = 1'b0;
							end else begin
								resp_d = dtq_pkg::STATUS_REJECTED;
							end
						end
						dtq_pkg::CMD_TICK: begin
							have_pend_d = 1'b0;
							cur_d       = head_q;
							if (head_q != dtq_pkg::NIL_LINK) begin
								state_d = dtq_pkg::ST_TICK_SUB;
							end
						end
						default: begin
							resp_d = dtq_pkg::STATUS_REJECTED;
						end
					endcase
				end
			end

			dtq_pkg::ST_RESP: begin
				emit_req  = 1'b1;
				em_status = resp_q;
				if (out_free) begin
					state_d = dtq_pkg::ST_IDLE;
				end
			end

			// Walk past every entry whose delta fits into what is left of the delay.
			dtq_pkg::ST_INS_WALK: begin
				alu_a   = dly_q;
				alu_b   = rd.delay;
				alu_sub = 1'b1;
				if (cur_q != dtq_pkg::NIL_LINK && !alu_neg) begin
					dly_d = alu_sum;
					prv_d = cur_q;
					cur_d = rd.next;
				end else begin
					state_d = dtq_pkg::ST_INS_LINK;
				end
			end

			dtq_pkg::ST_INS_LINK: begin
				wr.en_delay = 1'b1;
				wr.en_next  = 1'b1;
				wr.en_prev  = 1'b1;
				wr.addr     = slot_q[SW-1:0];
				wr.delay    = dly_q;
				wr.next     = cur_q;
				wr.prev     = prv_q;
				in_list_d[slot_q[SW-1:0]] = 1'b1;
				state_d     = dtq_pkg::ST_INS_FIX_PREV;
			end

			dtq_pkg::ST_INS_FIX_PREV: begin
				if (prv_q != dtq_pkg::NIL_LINK) begin
					wr.en_next = 1'b1;
					wr.addr    = prv_q[SW-1:0];
					wr.next    = slot_q;
				end else begin
					head_d = slot_q;
				end
				if (cur_q != dtq_pkg::NIL_LINK) begin
					state_d = dtq_pkg::ST_INS_FIX_NEXT;
				end else begin
					state_d = dtq_pkg::ST_RESP;
				end
			end

			dtq_pkg::ST_INS_FIX_NEXT: begin
				alu_sub     = 1'b1;
				wr.en_delay = 1'b1;
				wr.en_prev  = 1'b1;
				wr.addr     = cur_q[SW-1:0];
				wr.delay    = alu_sum;
				wr.prev     = slot_q;
				state_d     = dtq_pkg::ST_RESP;
			end

			dtq_pkg::ST_RM_READ: begin
				cur_d = rd.next;
				prv_d = rd.prev;
				dly_d = rd.delay;
				in_list_d[slot_q[SW-1:0]] = 1'b0;
				if (rd.next != dtq_pkg::NIL_LINK) begin
					state_d = dtq_pkg::ST_RM_FIX_NEXT;
				end else begin
					state_d = dtq_pkg::ST_RM_FIX_PREV;
				end
			end

			// The successor inherits the removed entry's delta.
			dtq_pkg::ST_RM_FIX_NEXT: begin
				wr.en_delay = 1'b1;
				wr.en_prev  = 1'b1;
				wr.addr     = cur_q[SW-1:0];
				wr.delay    = alu_sum;
				wr.prev     = prv_q;
				state_d     = dtq_pkg::ST_RM_FIX_PREV;
			end

			dtq_pkg::ST_RM_FIX_PREV: begin
				if (prv_q != dtq_pkg::NIL_LINK) begin
					wr.en_next = 1'b1;
					wr.addr    = prv_q[SW-1:0];
					wr.next    = cur_q;
				end else begin
					head_d = cur_q;
				end
				state_d = dtq_pkg::ST_RESP;
			end

			dtq_pkg::ST_TICK_SUB: begin
				alu_b   = DW'(elapsed_q);
				alu_sub = 1'b1;
				dly_d   = alu_sum;
				state_d = dtq_pkg::ST_TICK_CHECK;
			end

			// An expired slot is held back until it is known whether it is the last one.
			dtq_pkg::ST_TICK_CHECK: begin
				if (expire) begin
					if (have_pend_q) begin
						emit_req  = 1'b1;
						em_status = dtq_pkg::STATUS_EXPIRED;
						em_slot   = pend_q;
						em_last   = 1'b0;
					end
					if (!have_pend_q || out_free) begin
						pend_d      = cur_q;
						have_pend_d = 1'b1;
						state_d     = dtq_pkg::ST_TICK_NEXT;
					end
				end else begin
					emit_req = 1'b1;
					if (have_pend_q) begin
						em_status = dtq_pkg::STATUS_EXPIRED;
						em_slot   = pend_q;
					end
					if (out_free) begin
						wr.en_delay = 1'b1;
						wr.en_prev  = 1'b1;
						wr.addr     = cur_q[SW-1:0];
						wr.delay    = dly_q;
						wr.prev     = dtq_pkg::NIL_LINK;
						head_d      = cur_q;
						state_d     = dtq_pkg::ST_IDLE;
					end
				end
			end

			dtq_pkg::ST_TICK_NEXT: begin
				in_list_d[cur_q[SW-1:0]] = 1'b0;
				if (rd.next == dtq_pkg::NIL_LINK) begin
					emit_req  = 1'b1;
					em_status = dtq_pkg::STATUS_EXPIRED;
					em_slot   = pend_q;
					if (out_free) begin
						head_d  = dtq_pkg::NIL_LINK;
						state_d = dtq_pkg::ST_IDLE;
					end
				end else begin
					cur_d   = rd.next;
					state_d = dtq_pkg::ST_TICK_ADD;
				end
			end

			// A negative remainder carries into the next entry.
			dtq_pkg::ST_TICK_ADD: begin
				dly_d   = alu_sum;
				state_d = dtq_pkg::ST_TICK_CHECK;
			end

			default: begin
				state_d = dtq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtq_pkg::ST_IDLE;
			in_list_q   <= '0;
			in_wait_q   <= '0;
			head_q      <= dtq_pkg::NIL_LINK;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_list_q   <= in_list_d;
			in_wait_q   <= in_wait_d;
			head_q      <= head_d;
			have_pend_q <= have_pend_d;
			if (emit_req && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q    <= slot_d;
		cur_q     <= cur_d;
		prv_q     <= prv_d;
		pend_q    <= pend_d;
		dly_q     <= dly_d;
		elapsed_q <= elapsed_d;
		resp_q    <= resp_d;
		if (emit_req && out_free) begin
			status_q  <= em_status;
			expired_q <= 4'(em_slot);
			last_q    <= em_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign expired_slot = expired_q;
	assign last         = last_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the delta-list timer queue core.
// The model of the queue is kept in this file; the block's types and codes come from dtq_pkg.
// Directed requests come first, then a full list and random traffic, with idling on both sides.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         SETTLE_CYCLES = 100;

	typedef struct {
		logic [1:0] status;
		logic [3:0] slot;
		logic       last;
	} timer_result_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  command      = dtq_pkg::CMD_INSERT;
	logic [3:0]  slot_id      = '0;
	logic [30:0] delay_ticks  = '0;
	logic        wait_forever = 1'b0;
	logic [15:0] tick_delta   = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [1:0]  status;
	logic [3:0]  expired_slot;
	logic        last;

	// Model of the queue: deltas, links and membership of every slot.
	longint                     slot_delta [dtq_pkg::SLOT_COUNT];
	logic [dtq_pkg::LINK_W-1:0] next_slot  [dtq_pkg::SLOT_COUNT];
	logic [dtq_pkg::LINK_W-1:0] prev_slot  [dtq_pkg::SLOT_COUNT];
	bit                         in_list    [dtq_pkg::SLOT_COUNT];
	bit                         in_wait    [dtq_pkg::SLOT_COUNT];
	logic [dtq_pkg::LINK_W-1:0] head_slot  = dtq_pkg::NIL_LINK;

	timer_result_t expected_results[$];
	timer_result_t monitor_exp;
	int            fail_count = 0;
	int            burst_left = 0;

	delta_delay_timer_queue_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.slot_id      (slot_id),
		.delay_ticks  (delay_ticks),
		.wait_forever (wait_forever),
		.tick_delta   (tick_delta),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.expired_slot (expired_slot),
		.last         (last)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < dtq_pkg::SLOT_COUNT; i++) begin
			in_list[i]   = 1'b0;
			in_wait[i]   = 1'b0;
			next_slot[i] = dtq_pkg::NIL_LINK;
			prev_slot[i] = dtq_pkg::NIL_LINK;
			slot_delta[i] = 0;
		end
	end

	function automatic void push_result(input logic [1:0] st, input logic [3:0] sl,
			input logic lst);
		timer_result_t r;
		r.status = st;
		r.slot   = sl;
		r.last   = lst;
		expected_results.push_back(r);
	endfunction

	function automatic void link_timed(input int s, input longint delay);
		longint                     d;
		logic [dtq_pkg::LINK_W-1:0] pv;
		logic [dtq_pkg::LINK_W-1:0] nx;
		d  = delay;
		pv = dtq_pkg::NIL_LINK;
		nx = head_slot;
		// Entries with an equal delay stay ahead of the new one.
		while (nx < dtq_pkg::SLOT_COUNT && slot_delta[nx] <= d) begin
			d  = d - slot_delta[nx];
			pv = nx;
			nx = next_slot[nx];
		end
		slot_delta[s] = d;
		prev_slot[s]  = pv;
		next_slot[s]  = nx;
		if (pv < dtq_pkg::SLOT_COUNT)
			next_slot[pv] = dtq_pkg::LINK_W'(s);
		else
			head_slot = dtq_pkg::LINK_W'(s);
		if (nx < dtq_pkg::SLOT_COUNT) begin
			slot_delta[nx] = slot_delta[nx] - d;
			prev_slot[nx]  = dtq_pkg::LINK_W'(s);
		end
		in_list[s] = 1'b1;
	endfunction

	function automatic void unlink_timed(input int s);
		logic [dtq_pkg::LINK_W-1:0] nx;
		logic [dtq_pkg::LINK_W-1:0] pv;
		nx = next_slot[s];
		pv = prev_slot[s];
		if (nx < dtq_pkg::SLOT_COUNT) begin
			slot_delta[nx] = slot_delta[nx] + slot_delta[s];
			prev_slot[nx]  = pv;
		end
		if (pv < dtq_pkg::SLOT_COUNT)
			next_slot[pv] = nx;
		else
			head_slot = nx;
		next_slot[s] = dtq_pkg::NIL_LINK;
		prev_slot[s] = dtq_pkg::NIL_LINK;
		in_list[s]   = 1'b0;
	endfunction

	function automatic void apply_tick(input logic [15:0] elapsed);
		logic [dtq_pkg::LINK_W-1:0] h;
		logic [dtq_pkg::LINK_W-1:0] nx;
		timer_result_t              pending;
		bit                         have_pending;
		h = head_slot;
		have_pending = 1'b0;
		if (h < dtq_pkg::SLOT_COUNT) begin
			slot_delta[h] = slot_delta[h] - longint'(elapsed);
			// An overshoot of one entry carries into the next one.
			while (h < dtq_pkg::SLOT_COUNT && slot_delta[h] <= 0) begin
				nx = next_slot[h];
				if (nx < dtq_pkg::SLOT_COUNT)
					slot_delta[nx] = slot_delta[nx] + slot_delta[h];
				next_slot[h] = dtq_pkg::NIL_LINK;
				prev_slot[h] = dtq_pkg::NIL_LINK;
				in_list[h]   = 1'b0;
				if (have_pending)
					expected_results.push_back(pending);
				pending.status = dtq_pkg::STATUS_EXPIRED;
				pending.slot   = h[3:0];
				pending.last   = 1'b0;
				have_pending   = 1'b1;
				h = nx;
			end
			if (h < dtq_pkg::SLOT_COUNT)
				prev_slot[h] = dtq_pkg::NIL_LINK;
			head_slot = h;
		end
		if (have_pending) begin
			pending.last = 1'b1;
			expected_results.push_back(pending);
		end else begin
			push_result(dtq_pkg::STATUS_DONE, 4'd0, 1'b1);
		end
	endfunction

	function automatic void predict_request(input logic [1:0] cmd, input logic [3:0] slot,
			input logic [30:0] delay, input logic forever_wait, input logic [15:0] elapsed);
		int s;
		s = slot;
		case (cmd)
			dtq_pkg::CMD_INSERT: begin
				if (in_list[s] || in_wait[s]) begin
					push_result(dtq_pkg::STATUS_REJECTED, 4'd0, 1'b1);
				end else begin
					if (forever_wait)
						in_wait[s] = 1'b1;
					else
						link_timed(s, longint'(delay));
					push_result(dtq_pkg::STATUS_DONE, 4'd0, 1'b1);
				end
			end
			dtq_pkg::CMD_REMOVE: begin
				if (in_list[s]) begin
					unlink_timed(s);
					push_result(dtq_pkg::STATUS_DONE, 4'd0, 1'b1);
				end else if (in_wait[s]) begin
					in_wait[s] = 1'b0;
					push_result(dtq_pkg::STATUS_DONE, 4'd0, 1'b1);
				end else begin
					push_result(dtq_pkg::STATUS_REJECTED, 4'd0, 1'b1);
				end
			end
			dtq_pkg::CMD_TICK: begin
				apply_tick(elapsed);
			end
			default: begin
				push_result(dtq_pkg::STATUS_REJECTED, 4'd0, 1'b1);
			end
		endcase
	endfunction

	// Chooses a slot that is busy (timed or waiting) or free, falling back to any slot.
	function automatic logic [3:0] pick_slot(input bit want_busy);
		int cand[$];
		for (int i = 0; i < dtq_pkg::SLOT_COUNT; i++) begin
			if ((in_list[i] || in_wait[i]) == want_busy)
				cand.push_back(i);
		end
		if (cand.size() == 0)
			return 4'($urandom_range(0, 15));
		return 4'(cand[$urandom_range(0, cand.size() - 1)]);
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [3:0] slot,
			input logic [30:0] delay, input logic forever_wait, input logic [15:0] elapsed);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid     <= 1'b1;
		command      <= cmd;
		slot_id      <= slot;
		delay_ticks  <= delay;
		wait_forever <= forever_wait;
		tick_delta   <= elapsed;
		do
			@(posedge clk);
		while (in_stall);
		predict_request(cmd, slot, delay, forever_wait, elapsed);
	endtask

	// Holds the sender off until every outstanding result has been seen.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_insert_remove_rules();
		send_request(dtq_pkg::CMD_INSERT, 4'd0, 31'd0, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd15, 31'h7FFF_FFFF, 1'b0, 16'hFFFF);
		send_request(dtq_pkg::CMD_INSERT, 4'd3, 31'($urandom), 1'b1, 16'($urandom));
		// A slot already waiting or already timed cannot be inserted again.
		send_request(dtq_pkg::CMD_INSERT, 4'd3, 31'd5, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd0, 31'd9, 1'b1, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd7, 31'd0, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd9, 31'd100, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_REMOVE, 4'd5, 31'($urandom), 1'b0, 16'($urandom));
		send_request(CMD_UNUSED, 4'd15, 31'h7FFF_FFFF, 1'b1, 16'hFFFF);
		send_request(dtq_pkg::CMD_REMOVE, 4'd9, 31'($urandom), 1'b1, 16'($urandom));
		send_request(dtq_pkg::CMD_REMOVE, 4'd3, 31'($urandom), 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_REMOVE, 4'd3, 31'($urandom), 1'b0, 16'($urandom));
	endtask

	task automatic test_tick_expiry();
		// Entries with a zero delta at the head expire even on a zero tick.
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'b0, 16'd0);
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'b1, 16'hFFFF);
		send_request(dtq_pkg::CMD_REMOVE, 4'd15, 31'($urandom), 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'b0, 16'd0);
		send_request(dtq_pkg::CMD_INSERT, 4'd1, 31'd10, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd2, 31'd10, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_INSERT, 4'd4, 31'd30, 1'b0, 16'($urandom));
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'b0, 16'd15);
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'b0, 16'd15);
	endtask

	task automatic test_full_list();
		for (int i = 0; i < dtq_pkg::SLOT_COUNT; i++)
			send_request(dtq_pkg::CMD_REMOVE, 4'(i), 31'($urandom), 1'($urandom),
				16'($urandom));
		for (int i = 0; i < dtq_pkg::SLOT_COUNT; i++)
			send_request(dtq_pkg::CMD_INSERT, 4'(i), 31'($urandom_range(0, 40)), 1'b0,
				16'($urandom));
		// Every slot runs out on one tick.
		send_request(dtq_pkg::CMD_TICK, 4'($urandom), 31'($urandom), 1'($urandom),
			16'hFFFF);
	endtask

	task automatic test_random_traffic(input int count);
		int          roll;
		logic [1:0]  cmd;
		logic [3:0]  slot;
		logic [30:0] delay;
		logic        forever_wait;
		logic [15:0] elapsed;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 24) == 0)
				wait_drain();
			slot         = 4'($urandom_range(0, 15));
			delay        = 31'($urandom);
			forever_wait = 1'($urandom_range(0, 1));
			elapsed      = 16'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				cmd = dtq_pkg::CMD_INSERT;
				slot = ($urandom_range(0, 99) < 85) ? pick_slot(1'b0) : slot;
				forever_wait = ($urandom_range(0, 5) == 0);
				roll = $urandom_range(0, 9);
				if (roll < 6)
					delay = 31'($urandom_range(0, 300));
				else if (roll < 8)
					delay = 31'($urandom_range(0, 5));
			end else if (roll < 65) begin
				cmd = dtq_pkg::CMD_REMOVE;
				slot = ($urandom_range(0, 99) < 80) ? pick_slot(1'b1) : slot;
			end else if (roll < 97) begin
				cmd = dtq_pkg::CMD_TICK;
				roll = $urandom_range(0, 19);
				if (roll < 14)
					elapsed = 16'($urandom_range(0, 80));
				else if (roll < 17)
					elapsed = 16'd0;
			end else begin
				cmd = CMD_UNUSED;
			end
			send_request(cmd, slot, delay, forever_wait, elapsed);
		end
	endtask

	// Receiver stall: the pattern changes every so often between none, random and periodic.
	int unsigned stall_cycle = 0;
	int unsigned stall_mode  = 0;
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ((stall_cycle % 5) < 2);
			default: out_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d last=%0d",
					$time, status, expired_slot, last);
				fail_count++;
			end else begin
				monitor_exp = expected_results.pop_front();
				if (status !== monitor_exp.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, monitor_exp.status, status);
					fail_count++;
				end
				if (expired_slot !== monitor_exp.slot) begin
					$display("%0t: expired_slot expected %0d actual %0d",
						$time, monitor_exp.slot, expired_slot);
					fail_count++;
				end
				if (last !== monitor_exp.last) begin
					$display("%0t: last expected %0d actual %0d",
						$time, monitor_exp.last, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_insert_remove_rules();
		test_tick_expiry();
		wait_drain();
		test_full_list();
		wait_drain();
		test_random_traffic(170);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
